/* rtl/pfc_pkg.sv */
// Shared types and constants of the Playfair digraph cipher.
// No dependencies; taken in by the channel interfaces and the top level.
`timescale 1ns / 1ps

package pfc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [24:0] row_t;
  typedef row_t [4:0] square_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;

  typedef enum logic [2:0] {
    CFG_MODE = 3'd0,
    CFG_ROW0 = 3'd1,
    CFG_ROW1 = 3'd2,
    CFG_ROW2 = 3'd3,
    CFG_ROW3 = 3'd4,
    CFG_ROW4 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  // Up to two digraphs queued by one input word.
  typedef struct packed {
    letter_t a0;
    letter_t b0;
    letter_t a1;
    letter_t b1;
    logic    two;
  } job_t;

endpackage

/* rtl/pfc_if.sv */
// Valid/ready channel interfaces for letter words in and cipher words out.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

interface pfc_in_if import pfc_pkg::*;;
  logic    valid;
  logic    ready;
  letter_t letter_in;
  logic    message_end;

  modport source (output valid, output letter_in, output message_end, input ready);
  modport sink   (input valid, input letter_in, input message_end, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*;;
  logic    valid;
  logic    ready;
  letter_t letter_out;
  logic    run_last;

  modport source (output valid, output letter_out, output run_last, input ready);
  modport sink   (input valid, input letter_out, input run_last, output ready);
endinterface

/* rtl/playfair_digraph_cipher_top.sv */
// Playfair digraph cipher top level: pairing, key square lookup, output staging.
// Depends on pfc_pkg and the channel interfaces in pfc_if.sv.
// Path: the input word that completes a pair passes the job register, then the
// output pair register, before the pair is on out_ch.
// Throughput: one output word per cycle while out_ch.ready is high, set by the single
// output pair register; an input word is taken every cycle the job register is free.
// Reset (sync, rst_n low): no letter held, pipeline empty, mode and square zero.
`timescale 1ns / 1ps

module playfair_digraph_cipher_top import pfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pfc_in_if.sink       in_ch,
  pfc_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [24:0]  cfg_wdata
);

  // Configuration registers
  logic    mode_decrypt_r;
  square_t square_r;

  // Pairing state
  logic    held_valid_r, held_valid_nxt;
  letter_t held_letter_r, held_letter_nxt;

  // Job register: digraphs waiting for the cipher lookup
  logic job_valid_r, job_valid_nxt;
  job_t job_r, job_nxt;
  logic job_sel_r, job_sel_nxt;

  // Output pair register
  logic    pr_valid_r, pr_valid_nxt;
  logic    pr_idx_r, pr_idx_nxt;
  logic    pr_last_r, pr_last_nxt;
  letter_t pr_l0_r, pr_l0_nxt;
  letter_t pr_l1_r, pr_l1_nxt;

  logic    in_acc, out_acc, pr_free, pr_load, job_done;
  letter_t letter;
  logic    new_job;
  job_t    new_job_val;

  letter_t cur_a, cur_b, enc_a, enc_b;
  pos_t    pa, pb, qa, qb;

  // Last matching cell in row-major order wins; no match lands on row 0, column 0.
  function automatic pos_t locate(input square_t sq, input letter_t l);
    pos_t p;
    p = '0;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (sq[r][5*c +: 5] == l) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic letter_t cell_at(input square_t sq, input pos_t p);
    logic [4:0] off;
    off = {p.col[2:0], 2'b00} + {2'b00, p.col};
    return sq[p.row][off +: 5];
  endfunction

  // Advance one place around a row or column: +1 encrypting, -1 decrypting.
  function automatic coord_t wrap_step(input coord_t v, input logic dec);
    coord_t s;
    if (dec) begin
      s = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      s = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return s;
  endfunction

  // Configuration writes; indexes past the last row are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_decrypt_r <= 1'b0;
      square_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MODE: mode_decrypt_r <= cfg_wdata[0];
        CFG_ROW0: square_r[0]    <= cfg_wdata;
        CFG_ROW1: square_r[1]    <= cfg_wdata;
        CFG_ROW2: square_r[2]    <= cfg_wdata;
        CFG_ROW3: square_r[3]    <= cfg_wdata;
        CFG_ROW4: square_r[4]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshakes. The pair register frees up as its second word is taken,
  // and the job register as its final digraph moves into the pair register.
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign pr_free  = !pr_valid_r || (out_acc && pr_idx_r);
  assign pr_load  = job_valid_r && pr_free;
  assign job_done = pr_load && (job_sel_r || !job_r.two);
  assign in_ch.ready = !job_valid_r || job_done;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Pairing rules on the accepted letter (J folds onto I).
  assign letter = (in_ch.letter_in == LETTER_J) ? LETTER_I : in_ch.letter_in;

  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    new_job         = 1'b0;
    new_job_val     = '0;
    if (in_acc) begin
      if (mode_decrypt_r) begin
        if (held_valid_r) begin
          new_job         = 1'b1;
          new_job_val.a0  = held_letter_r;
          new_job_val.b0  = letter;
          held_valid_nxt  = 1'b0;
        end else if (!in_ch.message_end) begin
          held_letter_nxt = letter;
          held_valid_nxt  = 1'b1;
        end
      end else begin
        if (held_valid_r) begin
          new_job        = 1'b1;
          new_job_val.a0 = held_letter_r;
          if (held_letter_r == letter) begin
            // Doubled letter: split with filler X, keep the second letter held
            // unless the message ends here, then close it with X as well.
            new_job_val.b0 = LETTER_X;
            if (in_ch.message_end) begin
              new_job_val.a1  = letter;
              new_job_val.b1  = LETTER_X;
              new_job_val.two = 1'b1;
            end
          end else begin
            new_job_val.b0 = letter;
            held_valid_nxt = 1'b0;
          end
        end else if (in_ch.message_end) begin
          new_job        = 1'b1;
          new_job_val.a0 = letter;
          new_job_val.b0 = LETTER_X;
        end else begin
          held_letter_nxt = letter;
          held_valid_nxt  = 1'b1;
        end
      end
      if (in_ch.message_end) begin
        held_valid_nxt = 1'b0;
      end
    end
  end

  // Job register: load a new job, or step to its second digraph.
  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    job_sel_nxt   = job_sel_r;
    if (job_done) begin
      job_valid_nxt = 1'b0;
      job_sel_nxt   = 1'b0;
    end else if (pr_load) begin
      job_sel_nxt = 1'b1;
    end
    if (new_job) begin
      job_valid_nxt = 1'b1;
      job_nxt       = new_job_val;
      job_sel_nxt   = 1'b0;
    end
  end

  // Key square lookup of the current digraph.
  assign cur_a = job_sel_r ? job_r.a1 : job_r.a0;
  assign cur_b = job_sel_r ? job_r.b1 : job_r.b0;

  always_comb begin
    pa = locate(square_r, cur_a);
    pb = locate(square_r, cur_b);
    qa = pa;
    qb = pb;
    if (pa.row == pb.row) begin
      qa.col = wrap_step(pa.col, mode_decrypt_r);
      qb.col = wrap_step(pb.col, mode_decrypt_r);
    end else if (pa.col == pb.col) begin
      qa.row = wrap_step(pa.row, mode_decrypt_r);
      qb.row = wrap_step(pb.row, mode_decrypt_r);
    end else begin
      // Rectangle: swap the columns.
      qa.col = pb.col;
      qb.col = pa.col;
    end
  end

  assign enc_a = cell_at(square_r, qa);
  assign enc_b = cell_at(square_r, qb);

  // Output pair register: drain first letter, then second.
  always_comb begin
    pr_valid_nxt = pr_valid_r;
    pr_idx_nxt   = pr_idx_r;
    pr_last_nxt  = pr_last_r;
    pr_l0_nxt    = pr_l0_r;
    pr_l1_nxt    = pr_l1_r;
    if (pr_load) begin
      pr_valid_nxt = 1'b1;
      pr_idx_nxt   = 1'b0;
      pr_last_nxt  = job_sel_r || !job_r.two;
      pr_l0_nxt    = enc_a;
      pr_l1_nxt    = enc_b;
    end else if (out_acc) begin
      if (pr_idx_r) begin
        pr_valid_nxt = 1'b0;
        pr_idx_nxt   = 1'b0;
      end else begin
        pr_idx_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      job_valid_r   <= 1'b0;
      job_sel_r     <= 1'b0;
      pr_valid_r    <= 1'b0;
      pr_idx_r      <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
      job_valid_r   <= job_valid_nxt;
      job_sel_r     <= job_sel_nxt;
      pr_valid_r    <= pr_valid_nxt;
      pr_idx_r      <= pr_idx_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    pr_last_r <= pr_last_nxt;
    pr_l0_r   <= pr_l0_nxt;
    pr_l1_r   <= pr_l1_nxt;
  end

  assign out_ch.valid      = pr_valid_r;
  assign out_ch.letter_out = pr_idx_r ? pr_l1_r : pr_l0_r;
  assign out_ch.run_last   = pr_idx_r && pr_last_r;

`ifndef SYNTHESIS
  // A message end always releases the held letter.
  a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.message_end) |=> !held_valid_r)
    else $error("held letter survived a message end");

  // The second digraph is only ever selected in a live two-digraph job.
  a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
    job_sel_r |-> (job_valid_r && job_r.two))
    else $error("second digraph selected without a two-digraph job");

  // A freshly loaded pair starts on its first letter.
  a_pair_start: assert property (@(posedge clk) disable iff (!rst_n)
    pr_load |=> (pr_valid_r && !pr_idx_r))
    else $error("pair register loaded but not presenting its first letter");
`endif

endmodule
